// ===== hdl/slxfp_pkg.sv =====
package slxfp_pkg;

  localparam logic [7:0]  SYNC_FIRST    = 8'hEF;
  localparam logic [7:0]  SYNC_SECOND   = 8'hAA;
  localparam logic [15:0] MAX_LEN_RESET = 16'd280;
  localparam int          HEADER_BYTES  = 3;
  localparam int          HDR_CNT_W     = $clog2(HEADER_BYTES);
  localparam int          APB_AW        = 3;

  localparam logic [HDR_CNT_W-1:0] HDR_ID     = HDR_CNT_W'(0);
  localparam logic [HDR_CNT_W-1:0] HDR_LEN_HI = HDR_CNT_W'(1);

  localparam logic [0:0] REG_MAX_LEN = 1'b0;

  typedef enum logic [3:0] {
    PH_SYNC_H  = 4'b0001,
    PH_SYNC_L  = 4'b0010,
    PH_HEADER  = 4'b0100,
    PH_PAYLOAD = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_HEADER   = 3'd1,
    EV_PAYLOAD  = 3'd2,
    EV_GOOD     = 3'd3,
    EV_BAD      = 3'd4,
    EV_TOO_LONG = 3'd5
  } event_t;

endpackage

// ===== hdl/sync_length_xor_frame_parser.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+--------------------------------------------
// in_      | in_valid / in_stall     | in_rx_byte[7:0]
// out_     | out_valid / out_stall   | out_event_res[2:0], out_data_byte[7:0],
//          |                         | out_payload_index[15:0], out_message_id[7:0],
//          |                         | out_frame_length[15:0], out_computed_xor[7:0]
// config   | psel/penable/pwrite     | paddr[2:0], pwdata/prdata[31:0], pready
//
// One item per cycle while in_stall is low; each byte yields one result, registered on accept.
// Parser state updates in the same cycle as the accept.
// Synchronous active-low reset returns to sync hunt and max length 280.
// in_stall is raised only while a result is held and out_stall is high.
module sync_length_xor_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_payload_index,
  output logic [7:0]  out_message_id,
  output logic [15:0] out_frame_length,
  output logic [7:0]  out_computed_xor,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [slxfp_pkg::APB_AW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slxfp_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [HDR_CNT_W-1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]            msg_id_r, msg_id_nxt;
  logic [7:0]            len_hi_r, len_hi_nxt;
  logic [15:0]           len_r, len_nxt;
  logic [15:0]           pay_cnt_r, pay_cnt_nxt;
  logic [7:0]            xor_r, xor_nxt;
  logic [15:0]           max_len_r;

  logic                  out_valid_r, out_valid_nxt;
  event_t                ev_r, ev_nxt;
  logic [7:0]            data_r;
  logic [15:0]           idx_r, idx_nxt;
  logic [7:0]            mid_r, mid_nxt;
  logic [15:0]           flen_r, flen_nxt;
  logic [7:0]            cx_r, cx_nxt;

  logic                  in_fire;
  logic                  cfg_wr;
  logic [15:0]           hdr_len;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;
  assign hdr_len  = {len_hi_r, in_rx_byte};

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[APB_AW-1] == REG_MAX_LEN);
  assign prdata = (paddr[APB_AW-1] == REG_MAX_LEN) ? {16'd0, max_len_r} : 32'd0;

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    msg_id_nxt  = msg_id_r;
    len_hi_nxt  = len_hi_r;
    len_nxt     = len_r;
    pay_cnt_nxt = pay_cnt_r;
    xor_nxt     = xor_r;
    ev_nxt      = EV_NONE;
    idx_nxt     = 16'd0;
    mid_nxt     = 8'd0;
    flen_nxt    = 16'd0;
    cx_nxt      = 8'd0;
    case (phase_r)
      PH_SYNC_H: begin
        if (in_rx_byte == SYNC_FIRST) phase_nxt = PH_SYNC_L;
      end
      PH_SYNC_L: begin
        if (in_rx_byte == SYNC_SECOND) begin
          phase_nxt   = PH_HEADER;
          hdr_cnt_nxt = HDR_ID;
          xor_nxt     = 8'd0;
          len_nxt     = 16'd0;
          pay_cnt_nxt = 16'd0;
        end else if (in_rx_byte != SYNC_FIRST) begin
          phase_nxt = PH_SYNC_H;
        end
      end
      PH_HEADER: begin
        xor_nxt = xor_r ^ in_rx_byte;
        ev_nxt  = EV_HEADER;
        if (hdr_cnt_r == HDR_ID) begin
          msg_id_nxt  = in_rx_byte;
          hdr_cnt_nxt = HDR_LEN_HI;
        end else if (hdr_cnt_r == HDR_LEN_HI) begin
          len_hi_nxt  = in_rx_byte;
          hdr_cnt_nxt = HDR_CNT_W'(HEADER_BYTES - 1);
        end else begin
          len_nxt     = hdr_len;
          hdr_cnt_nxt = HDR_ID;
          pay_cnt_nxt = 16'd0;
          flen_nxt    = hdr_len;
          // drop the frame when the header length is over the limit
          if (hdr_len > max_len_r) begin
            ev_nxt    = EV_TOO_LONG;
            phase_nxt = PH_SYNC_H;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        mid_nxt = msg_id_nxt;
        cx_nxt  = xor_nxt;
      end
      PH_PAYLOAD: begin
        mid_nxt  = msg_id_r;
        flen_nxt = len_r;
        if (pay_cnt_r < len_r) begin
          xor_nxt     = xor_r ^ in_rx_byte;
          ev_nxt      = EV_PAYLOAD;
          idx_nxt     = pay_cnt_r;
          pay_cnt_nxt = pay_cnt_r + 16'd1;
          cx_nxt      = xor_nxt;
        end else begin
          cx_nxt    = xor_r;
          ev_nxt    = (in_rx_byte == xor_r) ? EV_GOOD : EV_BAD;
          phase_nxt = PH_SYNC_H;
        end
      end
      default: begin
        phase_nxt = PH_SYNC_H;
      end
    endcase
  end

  // hold a stalled result, load a new one on every accept
  always_comb begin
    if (in_fire) out_valid_nxt = 1'b1;
    else         out_valid_nxt = out_valid_r & out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC_H;
      hdr_cnt_r   <= HDR_ID;
      msg_id_r    <= 8'd0;
      len_hi_r    <= 8'd0;
      len_r       <= 16'd0;
      pay_cnt_r   <= 16'd0;
      xor_r       <= 8'd0;
      max_len_r   <= MAX_LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) max_len_r <= pwdata[15:0];
      if (in_fire) begin
        phase_r   <= phase_nxt;
        hdr_cnt_r <= hdr_cnt_nxt;
        msg_id_r  <= msg_id_nxt;
        len_hi_r  <= len_hi_nxt;
        len_r     <= len_nxt;
        pay_cnt_r <= pay_cnt_nxt;
        xor_r     <= xor_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ev_r   <= ev_nxt;
      data_r <= in_rx_byte;
      idx_r  <= idx_nxt;
      mid_r  <= mid_nxt;
      flen_r <= flen_nxt;
      cx_r   <= cx_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = ev_r;
  assign out_data_byte     = data_r;
  assign out_payload_index = idx_r;
  assign out_message_id    = mid_r;
  assign out_frame_length  = flen_r;
  assign out_computed_xor  = cx_r;

  a_pay_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (ev_r == EV_PAYLOAD) |-> (idx_r < flen_r))
    else $error("payload index not below frame length");

  a_none_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (ev_r == EV_NONE) |-> (mid_r == 8'd0) && (flen_r == 16'd0) &&
      (cx_r == 8'd0) && (idx_r == 16'd0))
    else $error("sync result carries frame fields");

  a_pay_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (phase_r == PH_PAYLOAD) && (pay_cnt_r < len_r)
      |=> (pay_cnt_r == $past(pay_cnt_r) + 16'd1))
    else $error("payload count did not advance");

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with no held result");

endmodule

// ===== tb/sv/tb_sync_length_xor_frame_parser.sv =====
module tb_sync_length_xor_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import slxfp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam logic [APB_AW-1:0] MAX_LEN_ADDR = APB_AW'(4 * REG_MAX_LEN);
  localparam logic [APB_AW-1:0] UNMAPPED_ADDR = APB_AW'(4 * (REG_MAX_LEN + 1));

  typedef struct packed {
    event_t      ev;
    logic [7:0]  data;
    logic [15:0] idx;
    logic [7:0]  id;
    logic [15:0] flen;
    logic [7:0]  cx;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_data_byte;
  logic [15:0] out_payload_index;
  logic [7:0]  out_message_id;
  logic [15:0] out_frame_length;
  logic [7:0]  out_computed_xor;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  // parser copy used for prediction
  phase_t               hunt_phase;
  logic [HDR_CNT_W-1:0] hdr_cnt;
  logic [7:0]           cur_id;
  logic [7:0]           len_hi;
  logic [15:0]          cur_len;
  logic [15:0]          pay_cnt;
  logic [7:0]           xor_acc;
  logic [15:0]          max_len;

  logic [7:0]    tx_bytes[$];
  frame_result_t expected_results[$];
  int            mismatches = 0;
  int            cycles = 0;
  int            send_idle_pct = 18;
  int            recv_idle_pct = 85;
  logic          hold_req = 1'b0;
  logic          hold_seen = 1'b0;
  int            hold_left = 0;

  sync_length_xor_frame_parser dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_data_byte     (out_data_byte),
    .out_payload_index (out_payload_index),
    .out_message_id    (out_message_id),
    .out_frame_length  (out_frame_length),
    .out_computed_xor  (out_computed_xor),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic log_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic append_byte(input logic [7:0] b);
    tx_bytes = {tx_bytes, b};
  endtask

  task automatic predict_byte(input logic [7:0] b);
    frame_result_t r;
    r = '{ev: EV_NONE, data: b, idx: '0, id: '0, flen: '0, cx: '0};
    case (hunt_phase)
      PH_SYNC_H: if (b == SYNC_FIRST) hunt_phase = PH_SYNC_L;
      PH_SYNC_L: begin
        if (b == SYNC_SECOND) begin
          hunt_phase = PH_HEADER;
          hdr_cnt = HDR_ID;
          xor_acc = '0;
          cur_len = '0;
          pay_cnt = '0;
        end else if (b != SYNC_FIRST) begin
          hunt_phase = PH_SYNC_H;
        end
      end
      PH_HEADER: begin
        xor_acc = xor_acc ^ b;
        r.ev = EV_HEADER;
        if (hdr_cnt == HDR_ID) begin
          cur_id = b;
          hdr_cnt = HDR_LEN_HI;
        end else if (hdr_cnt == HDR_LEN_HI) begin
          len_hi = b;
          hdr_cnt = HDR_LEN_HI + 1'b1;
        end else begin
          cur_len = {len_hi, b};
          hdr_cnt = HDR_ID;
          pay_cnt = '0;
          r.flen = cur_len;
          if (cur_len > max_len) begin
            r.ev = EV_TOO_LONG;
            hunt_phase = PH_SYNC_H;
          end else begin
            hunt_phase = PH_PAYLOAD;
          end
        end
        r.id = cur_id;
        r.cx = xor_acc;
      end
      default: begin
        r.id = cur_id;
        r.flen = cur_len;
        if (pay_cnt < cur_len) begin
          xor_acc = xor_acc ^ b;
          r.ev = EV_PAYLOAD;
          r.idx = pay_cnt;
          pay_cnt = pay_cnt + 1'b1;
        end else begin
          r.ev = (b == xor_acc) ? EV_GOOD : EV_BAD;
          hunt_phase = PH_SYNC_H;
        end
        r.cx = xor_acc;
      end
    endcase
    expected_results = {expected_results, r};
  endtask

  // driver: advance to the next item once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_rx_byte <= 8'h00;
    end else begin
      if (in_valid && !in_stall) predict_byte(in_rx_byte);
      if (!in_valid || !in_stall) begin
        if (tx_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        log_mismatch($sformatf("result with nothing expected, event %0d", out_event_res));
      end else begin
        want = expected_results.pop_front();
        check_field("event_res", 16'(out_event_res), 16'(want.ev));
        check_field("data_byte", 16'(out_data_byte), 16'(want.data));
        check_field("payload_index", out_payload_index, want.idx);
        check_field("message_id", 16'(out_message_id), 16'(want.id));
        check_field("frame_length", out_frame_length, want.flen);
        check_field("computed_xor", 16'(out_computed_xor), 16'(want.cx));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(99, 0);
    if (r < 10) return SYNC_FIRST;
    if (r < 15) return SYNC_SECOND;
    return 8'($urandom);
  endfunction

  function automatic int pick_length();
    int r, l;
    r = $urandom_range(99, 0);
    if (r < 10 && max_len < 300) l = int'(max_len) - 1 + $urandom_range(2, 0);
    else if (r < 16) l = $urandom_range(65535, 0);
    else l = $urandom_range(12, 0);
    if (l < 0) l = 0;
    // keep accepted frames short
    if (l <= max_len && l > 300) l = l % 13;
    return l;
  endfunction

  task automatic queue_traffic(input int n);
    int pushed, r, len, k;
    logic [7:0] id, chk, b;
    pushed = 0;
    while (pushed < n) begin
      r = $urandom_range(99, 0);
      if (r < 78) begin
        id = 8'($urandom);
        len = pick_length();
        append_byte(SYNC_FIRST);
        append_byte(SYNC_SECOND);
        append_byte(id);
        append_byte(len[15:8]);
        append_byte(len[7:0]);
        chk = id ^ len[15:8] ^ len[7:0];
        pushed += 5;
        if (len <= max_len) begin
          for (k = 0; k < len; k++) begin
            b = rand_byte();
            chk = chk ^ b;
            append_byte(b);
          end
          if ($urandom_range(99, 0) < 20) chk = chk ^ 8'($urandom_range(255, 1));
          append_byte(chk);
          pushed += len + 1;
        end
      end else if (r < 88) begin
        // cut a frame short: broken sync pair, or a sync pair followed by up to three header bytes
        append_byte(SYNC_FIRST);
        k = (max_len > 300) ? 0 : $urandom_range(3, 0);
        if (k == 0) begin
          append_byte(8'($urandom));
        end else begin
          append_byte(SYNC_SECOND);
          repeat (k) append_byte(rand_byte());
        end
        pushed += 2 + k;
      end else begin
        append_byte(rand_byte());
        pushed++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (tx_bytes.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == MAX_LEN_ADDR) max_len = data[15:0];
  endtask

  task automatic check_limit_reg();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= MAX_LEN_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== max_len)
      log_mismatch($sformatf("max length readback got %0h want %0h", prdata[15:0], max_len));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [7:0] directed[$];
    hunt_phase = PH_SYNC_H;
    hdr_cnt = HDR_ID;
    cur_id = '0;
    len_hi = '0;
    cur_len = '0;
    pay_cnt = '0;
    xor_acc = '0;
    max_len = MAX_LEN_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte extremes, broken sync, repeated first sync byte with a zero-length frame,
    // a length one above the limit, a good one-byte frame, a bad checksum
    directed = '{8'h00, 8'hFF, SYNC_FIRST, 8'h12,
                 SYNC_FIRST, SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h00, 8'h00, 8'h00,
                 SYNC_FIRST, SYNC_SECOND, 8'h01, 8'h01, 8'h19,
                 SYNC_FIRST, SYNC_SECOND, 8'h11, 8'h00, 8'h01, 8'h5A, 8'h4A,
                 SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h00, 8'h00, 8'hFF};
    foreach (directed[i]) append_byte(directed[i]);
    queue_traffic(450);
    wait_drained();
    check_limit_reg();

    apb_write(MAX_LEN_ADDR, {16'($urandom), 16'h0000});
    apb_write(UNMAPPED_ADDR, 32'($urandom));
    check_limit_reg();
    queue_traffic(200);
    wait_drained();

    @(negedge clk);
    send_idle_pct = 85;
    recv_idle_pct = 18;
    apb_write(MAX_LEN_ADDR, 32'h0000_FFFF);
    check_limit_reg();
    queue_traffic(400);
    wait_drained();

    apb_write(MAX_LEN_ADDR, 32'($urandom_range(60, 1)));
    queue_traffic(250);
    wait_drained();

    @(negedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write(MAX_LEN_ADDR, 32'($urandom_range(300, 200)));
    check_limit_reg();
    queue_traffic(350);
    // hold the output while the sender keeps offering items
    @(posedge clk);
    hold_req <= ~hold_req;
    wait_drained();
    repeat (4) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
